### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the integer arithmetic unit
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/moiau_pkg.sv
// ---------------------------------------------------------------------------
// moiau_pkg
// Types, widths and codes for the multi-operation integer arithmetic unit.
// ---------------------------------------------------------------------------
package moiau_pkg;

	// Operand width and quotient scaling
	localparam int DATA_W         = 32;
	localparam int QUOTIENT_SCALE = 100;

	// Word field widths
	localparam int MODE_W   = 4;
	localparam int FIRST_W  = 39;
	localparam int STATUS_W = 2;

	// Scaled dividend: magnitude of operand times the scale
	localparam int NUM_W  = DATA_W - 1 + $clog2(QUOTIENT_SCALE + 1);
	// Compare-subtract width: partial remainder plus one shifted-in bit
	localparam int CS_W   = DATA_W + 1;
	localparam int PROD_W = 2 * DATA_W;
	localparam int ROOT_W = DATA_W / 2;
	localparam int SREM_W = ROOT_W + 2;
	localparam int CNT_W  = $clog2(NUM_W);

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_ADD    = 4'd0;
	localparam logic [MODE_W-1:0] MODE_SUB    = 4'd1;
	localparam logic [MODE_W-1:0] MODE_MUL    = 4'd2;
	localparam logic [MODE_W-1:0] MODE_DIV    = 4'd3;
	localparam logic [MODE_W-1:0] MODE_REM    = 4'd4;
	localparam logic [MODE_W-1:0] MODE_POW    = 4'd5;
	localparam logic [MODE_W-1:0] MODE_SQUARE = 4'd6;
	localparam logic [MODE_W-1:0] MODE_CUBE   = 4'd7;
	localparam logic [MODE_W-1:0] MODE_SQRT   = 4'd8;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_DIV_ZERO = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NEG_SQRT = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
	} in_word_t;

	typedef struct packed {
		logic signed [FIRST_W-1:0] value_first;
		logic signed [DATA_W-1:0]  value_second;
		logic [STATUS_W-1:0]       status;
	} out_word_t;

	// Operands presented to the shared arithmetic unit
	typedef struct packed {
		logic [DATA_W-1:0] mul_x;
		logic [DATA_W-1:0] mul_y;
		logic [CS_W-1:0]   cs_l;
		logic [CS_W-1:0]   cs_r;
	} shared_req_t;

	// Results returned by the shared arithmetic unit
	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic [CS_W-1:0]   diff;
		logic              ge;
	} shared_rsp_t;

endpackage

### hdl/moiau_shared_unit.sv
// ---------------------------------------------------------------------------
// moiau_shared_unit
// One unsigned multiplier and one compare-subtract, shared by all operations
// but add and subtract, under the sequencer of the top level.
// ---------------------------------------------------------------------------
module moiau_shared_unit (
	input  moiau_pkg::shared_req_t req,
	output moiau_pkg::shared_rsp_t rsp
);

	logic [moiau_pkg::CS_W:0] diff_w;

	// Full-width unsigned product; callers take the bits they need
	assign rsp.prod = moiau_pkg::PROD_W'(req.mul_x) * moiau_pkg::PROD_W'(req.mul_y);

	// Subtract with borrow out; no borrow means cs_l >= cs_r
	assign diff_w   = {1'b0, req.cs_l} - {1'b0, req.cs_r};
	assign rsp.diff = diff_w[moiau_pkg::CS_W-1:0];
	assign rsp.ge   = ~diff_w[moiau_pkg::CS_W];

endmodule

### hdl/multi_op_integer_arith_unit.sv
// ---------------------------------------------------------------------------
// multi_op_integer_arith_unit
// Integer ALU with add, subtract, multiply, scaled rounded divide,
// remainder, power, square, cube and floor square root.
// ---------------------------------------------------------------------------
//  channel | signals                        | word
//  --------+--------------------------------+------------------------------
//  input   | in_valid / in_ready / in_data  | mode, operand_a, operand_b
//  output  | out_valid / out_ready/out_data | value_first, value_second, status
//
//  Add, sub, unused codes and the early-out error or negative-exponent
//  words go from acceptance directly to the result step; mul, square
//  and cube take multiplier passes; power squares and multiplies per
//  exponent bit; divide and remainder take one quotient bit per cycle,
//  divide after scaling the dividend; square root takes one root bit
//  per cycle, both operands in turn, all on the one shared multiplier and
//  subtractor. in_ready is high only while the sequencer is idle; a
//  finished result waits in the output register while the next word is
//  taken in. Reset clears the sequencer and the output valid flag.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_op_integer_arith_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  moiau_pkg::in_word_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output moiau_pkg::out_word_t  out_data
);

	localparam int DW = moiau_pkg::DATA_W;
	localparam int NW = moiau_pkg::NUM_W;
	localparam int RW = moiau_pkg::ROOT_W;
	localparam int SW = moiau_pkg::SREM_W;
	localparam int CW = moiau_pkg::CNT_W;
	localparam int FW = moiau_pkg::FIRST_W;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCALE = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_SQRT  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic                                  accept;
	logic                                  out_free;
	logic [moiau_pkg::MODE_W-1:0]          mode_q;
	logic [DW-1:0]                         a_q, b_q, opnd;
	logic [DW-1:0]                         in_mag_a, in_mag_b, a_mag;
	logic [DW-1:0]                         den_q, rem_q;
	logic [NW-1:0]                         num_q, quo_q;
	logic [DW-1:0]                         acc_q, base_q;
	logic [DW-2:0]                         exp_q;
	logic [DW-1:0]                         rad_q;
	logic [RW-1:0]                         root_q, root_next;
	logic [SW-1:0]                         srem_q;
	logic [CW-1:0]                         cnt_q;
	logic                                  slot_q, phase_q;
	logic [DW-1:0]                         res1_q, res2_q;
	logic [moiau_pkg::STATUS_W-1:0]        stat_q;
	logic                                  mul_last;
	moiau_pkg::shared_req_t                req;
	moiau_pkg::shared_rsp_t                rsp;
	moiau_pkg::out_word_t                  out_q, out_d;
	logic                                  out_valid_q;
	logic [NW-1:0]                         q_round;
	logic [FW-1:0]                         q_ext;
	logic [DW-1:0]                         rem_val, sum_val, dif_val;
	logic [moiau_pkg::STATUS_W-1:0]        init_stat;
	logic [DW-1:0]                         init_res1;
	logic [CW-1:0]                         init_cnt;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Operand magnitudes, two's complement
	assign in_mag_a  = in_data.operand_a[DW-1] ? (DW'(0) - in_data.operand_a) : in_data.operand_a;
	assign in_mag_b  = in_data.operand_b[DW-1] ? (DW'(0) - in_data.operand_b) : in_data.operand_b;
	assign a_mag     = a_q[DW-1] ? (DW'(0) - a_q) : a_q;
	assign opnd      = slot_q ? b_q : a_q;
	assign root_next = {root_q[RW-2:0], rsp.ge};

	moiau_shared_unit u_shared (
		.req (req),
		.rsp (rsp)
	);

	// Steer the shared unit by state
	always_comb begin
		req       = '0;
		req.mul_x = a_q;
		req.mul_y = b_q;
		unique case (state_q)
			ST_SCALE: begin
				req.mul_x = a_mag;
				req.mul_y = DW'(moiau_pkg::QUOTIENT_SCALE);
			end
			ST_MUL: begin
				case (mode_q) inside
					moiau_pkg::MODE_SQUARE, moiau_pkg::MODE_CUBE: begin
						req.mul_x = phase_q ? acc_q : opnd;
						req.mul_y = opnd;
					end
					moiau_pkg::MODE_POW: begin
						req.mul_x = phase_q ? base_q : acc_q;
						req.mul_y = base_q;
					end
					default: ;
				endcase
			end
			ST_DIV: begin
				req.cs_l = {rem_q, num_q[NW-1]};
				req.cs_r = moiau_pkg::CS_W'(den_q);
			end
			ST_SQRT: begin
				req.cs_l = moiau_pkg::CS_W'({srem_q, rad_q[DW-1:DW-2]});
				req.cs_r = moiau_pkg::CS_W'({root_q, 2'b01});
			end
			ST_FIN: begin
				// Round to nearest: twice the remainder against the divisor
				req.cs_l = {rem_q, 1'b0};
				req.cs_r = moiau_pkg::CS_W'(den_q);
			end
			default: ;
		endcase
	end

	// Last multiplier pass of the current operation
	always_comb begin
		case (mode_q) inside
			moiau_pkg::MODE_MUL:    mul_last = 1'b1;
			moiau_pkg::MODE_SQUARE: mul_last = slot_q;
			moiau_pkg::MODE_CUBE:   mul_last = slot_q && phase_q;
			moiau_pkg::MODE_POW:    mul_last = (exp_q == '0);
			default:                mul_last = 1'b1;
		endcase
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_data.mode) inside
						moiau_pkg::MODE_MUL, moiau_pkg::MODE_SQUARE, moiau_pkg::MODE_CUBE:
							state_d = ST_MUL;
						moiau_pkg::MODE_POW:
							state_d = in_data.operand_b[DW-1] ? ST_FIN : ST_MUL;
						moiau_pkg::MODE_DIV:
							state_d = (in_data.operand_b == '0) ? ST_FIN : ST_SCALE;
						moiau_pkg::MODE_REM:
							state_d = (in_data.operand_b == '0) ? ST_FIN : ST_DIV;
						moiau_pkg::MODE_SQRT:
							state_d = ST_SQRT;
						default:
							state_d = ST_FIN;
					endcase
				end
			end
			ST_SCALE: state_d = ST_DIV;
			ST_MUL:   if (mul_last) state_d = ST_FIN;
			ST_DIV:   if (cnt_q == '0) state_d = ST_FIN;
			ST_SQRT:  if (cnt_q == '0 && slot_q) state_d = ST_FIN;
			ST_FIN:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Status, early result and step count for an incoming word
	always_comb begin
		init_stat = moiau_pkg::STAT_OK;
		init_res1 = '0;
		init_cnt  = CW'(RW - 1);
		case (in_data.mode) inside
			moiau_pkg::MODE_DIV, moiau_pkg::MODE_REM: begin
				if (in_data.operand_b == '0)
					init_stat = moiau_pkg::STAT_DIV_ZERO;
				init_cnt = (in_data.mode == moiau_pkg::MODE_DIV) ?
					CW'(NW - 1) : CW'(DW - 1);
			end
			moiau_pkg::MODE_POW: begin
				// Negative exponent: only unit bases survive
				if (in_data.operand_b[DW-1]) begin
					if (in_data.operand_a == DW'(1))
						init_res1 = DW'(1);
					else if (in_data.operand_a == '1)
						init_res1 = in_data.operand_b[0] ? '1 : DW'(1);
					else if (in_data.operand_a == '0)
						init_stat = moiau_pkg::STAT_DIV_ZERO;
				end
			end
			moiau_pkg::MODE_SQRT: begin
				if (in_data.operand_a[DW-1] || in_data.operand_b[DW-1])
					init_stat = moiau_pkg::STAT_NEG_SQRT;
			end
			default: ;
		endcase
	end

	// Assemble the result word
	always_comb begin
		q_round = quo_q + NW'(rsp.ge);
		q_ext   = FW'(q_round);
		rem_val = a_q[DW-1] ? (DW'(0) - rem_q) : rem_q;
		sum_val = a_q + b_q;
		dif_val = a_q - b_q;
		out_d.value_second = res2_q;
		out_d.status       = stat_q;
		case (mode_q) inside
			moiau_pkg::MODE_ADD: out_d.value_first = FW'($signed(sum_val));
			moiau_pkg::MODE_SUB: out_d.value_first = FW'($signed(dif_val));
			moiau_pkg::MODE_DIV: begin
				if (stat_q != moiau_pkg::STAT_OK)
					out_d.value_first = '0;
				else if (a_q[DW-1] ^ b_q[DW-1])
					out_d.value_first = FW'(0) - q_ext;
				else
					out_d.value_first = q_ext;
			end
			moiau_pkg::MODE_REM: begin
				if (stat_q != moiau_pkg::STAT_OK)
					out_d.value_first = '0;
				else
					out_d.value_first = FW'($signed(rem_val));
			end
			default: out_d.value_first = FW'($signed(res1_q));
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free)
			out_q <= out_d;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_q  <= in_data.mode;
					a_q     <= in_data.operand_a;
					b_q     <= in_data.operand_b;
					res1_q  <= init_res1;
					res2_q  <= '0;
					stat_q  <= init_stat;
					slot_q  <= 1'b0;
					phase_q <= 1'b0;
					den_q   <= in_mag_b;
					rem_q   <= '0;
					quo_q   <= '0;
					num_q   <= NW'(in_mag_a) << (NW - DW);
					acc_q   <= DW'(1);
					base_q  <= in_data.operand_a;
					exp_q   <= in_data.operand_b[DW-2:0];
					rad_q   <= in_data.operand_a;
					root_q  <= '0;
					srem_q  <= '0;
					cnt_q   <= init_cnt;
				end
			end

			// Scale the dividend magnitude
			ST_SCALE: num_q <= rsp.prod[NW-1:0];

			// Multiply passes
			ST_MUL: begin
				case (mode_q) inside
					moiau_pkg::MODE_MUL: res1_q <= rsp.prod[DW-1:0];
					moiau_pkg::MODE_SQUARE: begin
						if (slot_q) res2_q <= rsp.prod[DW-1:0];
						else res1_q <= rsp.prod[DW-1:0];
						slot_q <= 1'b1;
					end
					moiau_pkg::MODE_CUBE: begin
						if (!phase_q) begin
							acc_q   <= rsp.prod[DW-1:0];
							phase_q <= 1'b1;
						end else begin
							if (slot_q) res2_q <= rsp.prod[DW-1:0];
							else res1_q <= rsp.prod[DW-1:0];
							phase_q <= 1'b0;
							slot_q  <= 1'b1;
						end
					end
					moiau_pkg::MODE_POW: begin
						// Square and multiply, low exponent bit first
						if (exp_q == '0) begin
							res1_q <= acc_q;
						end else if (!phase_q) begin
							if (exp_q[0]) acc_q <= rsp.prod[DW-1:0];
							phase_q <= 1'b1;
						end else begin
							base_q  <= rsp.prod[DW-1:0];
							exp_q   <= exp_q >> 1;
							phase_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end

			// Restoring division, one quotient bit per cycle
			ST_DIV: begin
				rem_q <= rsp.ge ? rsp.diff[DW-1:0] : req.cs_l[DW-1:0];
				quo_q <= {quo_q[NW-2:0], rsp.ge};
				num_q <= num_q << 1;
				cnt_q <= cnt_q - CW'(1);
			end

			// Digit-by-digit square root, one root bit per cycle
			ST_SQRT: begin
				if (cnt_q == '0) begin
					if (slot_q)
						res2_q <= opnd[DW-1] ? '0 : DW'(root_next);
					else
						res1_q <= opnd[DW-1] ? '0 : DW'(root_next);
					// Move on to the second operand
					slot_q <= 1'b1;
					rad_q  <= b_q;
					root_q <= '0;
					srem_q <= '0;
					cnt_q  <= CW'(RW - 1);
				end else begin
					root_q <= root_next;
					srem_q <= rsp.ge ? rsp.diff[SW-1:0] : req.cs_l[SW-1:0];
					rad_q  <= rad_q << 2;
					cnt_q  <= cnt_q - CW'(1);
				end
			end

			default: ;
		endcase
	end

	// Checks
	`ASSERT_IMPLIES(a_div_rem_below_den, clk, arst_n, state_q == ST_DIV, rem_q < den_q, "div remainder not below divisor")
	`ASSERT_NEXT(a_div_ends, clk, arst_n, state_q == ST_DIV && cnt_q == '0, state_q == ST_FIN, "divide overran")
	`ASSERT_IMPLIES(a_sqrt_rem_bound, clk, arst_n, state_q == ST_SQRT, srem_q <= SW'({root_q, 1'b0}), "sqrt remainder too large")
	`ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE, "word accepted but sequencer idle")

endmodule

### verif/arith_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer arithmetic unit scoreboard
// Watches both channels of the integer arithmetic unit, works out the result
// word for every operand word taken in, and compares each result word that
// leaves the block, field by field, against the oldest one outstanding.
// ----------------------------------------------------------------------------
module arith_checker
	import moiau_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_word_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_word_t out_data,
	output int        fail_count,
	output int        pending_count,
	output int        checked_count
);

	out_word_t pending_alu_words[$];
	in_word_t  issued_operands[$];
	out_word_t wanted_word;
	in_word_t  source_word;
	int        mismatches = 0;
	int        outstanding = 0;
	int        results_checked = 0;

	assign fail_count    = mismatches;
	assign pending_count = outstanding;
	assign checked_count = results_checked;

	// Print one line per mismatch and count it
	task automatic flag_mismatch(input string what);
		$display("[%0t ns] MISMATCH: %s", $realtime, what);
		mismatches++;
	endtask

	// Floor square root of a non-negative 32-bit value, one root bit at a time
	function automatic logic [DATA_W-1:0] floor_root(input logic [DATA_W-1:0] x);
		logic [DATA_W-1:0] root;
		logic [DATA_W-1:0] trial;
		root = '0;
		for (int i = DATA_W / 2 - 1; i >= 0; i--) begin
			trial = root | (32'd1 << i);
			if (trial * trial <= x)
				root = trial;
		end
		return root;
	endfunction

	// Wrapped power for a non-negative exponent by square and multiply
	function automatic logic [DATA_W-1:0] wrapped_power(input logic [DATA_W-1:0] base,
			input logic [DATA_W-1:0] expo);
		logic [DATA_W-1:0] acc;
		logic [DATA_W-1:0] sq;
		acc = 32'd1;
		sq  = base;
		for (int i = 0; i < DATA_W; i++) begin
			if (expo[i])
				acc = acc * sq;
			sq = sq * sq;
		end
		return acc;
	endfunction

	// Work out the result word for one operand word
	function automatic out_word_t compute_alu_word(input in_word_t w);
		out_word_t         res;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] abs_a;
		logic [DATA_W-1:0] abs_b;
		logic [63:0]       num;
		logic [63:0]       den;
		logic [63:0]       quo;
		logic [63:0]       rmd;
		res   = '0;
		lo    = '0;
		a     = w.operand_a;
		b     = w.operand_b;
		abs_a = a[DATA_W-1] ? 32'd0 - a : a;
		abs_b = b[DATA_W-1] ? 32'd0 - b : b;
		case (w.mode)
			MODE_ADD: lo = a + b;
			MODE_SUB: lo = a - b;
			MODE_MUL: lo = a * b;
			MODE_DIV: begin
				if (b == 0) begin
					res.status = STAT_DIV_ZERO;
				end else begin
					num = {32'd0, abs_a} * 64'd100;
					den = {32'd0, abs_b};
					quo = num / den;
					rmd = num % den;
					// round half away from zero on the magnitude
					if ((rmd << 1) >= den)
						quo = quo + 64'd1;
					if (a[DATA_W-1] ^ b[DATA_W-1])
						quo = 64'd0 - quo;
					res.value_first = quo[FIRST_W-1:0];
				end
			end
			MODE_REM: begin
				if (b == 0)
					res.status = STAT_DIV_ZERO;
				else begin
					lo = abs_a % abs_b;
					if (a[DATA_W-1])
						lo = 32'd0 - lo;
				end
			end
			MODE_POW: begin
				if (!b[DATA_W-1])
					lo = wrapped_power(a, b);
				else if (a == 32'sd1)
					lo = 32'd1;
				else if (a == -32'sd1)
					lo = b[0] ? '1 : 32'd1;
				else if (a == 32'sd0)
					res.status = STAT_DIV_ZERO;
			end
			MODE_SQUARE: begin
				lo = a * a;
				res.value_second = b * b;
			end
			MODE_CUBE: begin
				lo = a * a * a;
				res.value_second = b * b * b;
			end
			MODE_SQRT: begin
				// a negative side reads zero, the other side still gets its root
				if (a[DATA_W-1])
					res.status = STAT_NEG_SQRT;
				else
					lo = floor_root(a);
				if (b[DATA_W-1])
					res.status = STAT_NEG_SQRT;
				else
					res.value_second = floor_root(b);
			end
			default: ;
		endcase
		if (w.mode != MODE_DIV)
			res.value_first = {{(FIRST_W - DATA_W){lo[DATA_W-1]}}, lo};
		return res;
	endfunction

	// Retire result words first, then queue the prediction for a new operand word
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_alu_words.size() == 0) begin
					flag_mismatch($sformatf("result word %h with nothing outstanding", out_data));
				end else begin
					wanted_word = pending_alu_words.pop_front();
					source_word = issued_operands.pop_front();
					results_checked++;
					if (out_data.value_first !== wanted_word.value_first)
						flag_mismatch($sformatf("mode %0d a %0d b %0d: value_first %0d, want %0d",
							source_word.mode, source_word.operand_a, source_word.operand_b,
							out_data.value_first, wanted_word.value_first));
					if (out_data.value_second !== wanted_word.value_second)
						flag_mismatch($sformatf("mode %0d a %0d b %0d: value_second %0d, want %0d",
							source_word.mode, source_word.operand_a, source_word.operand_b,
							out_data.value_second, wanted_word.value_second));
					if (out_data.status !== wanted_word.status)
						flag_mismatch($sformatf("mode %0d a %0d b %0d: status %0d, want %0d",
							source_word.mode, source_word.operand_a, source_word.operand_b,
							out_data.status, wanted_word.status));
				end
			end
			if (in_valid && in_ready) begin
				pending_alu_words.push_back(compute_alu_word(in_data));
				issued_operands.push_back(in_data);
			end
			outstanding <= pending_alu_words.size();
		end
	end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer arithmetic unit testbench
// Drives directed corner words and then random operand words through the
// integer arithmetic unit under three pacing phases on both handshakes,
// while the scoreboard predicts and checks every result word.
// ----------------------------------------------------------------------------
module testbench;
	import moiau_pkg::*;

	localparam logic [MODE_W-1:0] MODE_TOP = 4'd15;
	localparam int WORDS_PER_PHASE = 585;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	int fail_count;
	int pending_count;
	int checked_count;
	int gap_pct = 0;
	int stall_pct = 0;
	int words_sent = 0;

	always #10 clk = ~clk;

	multi_op_integer_arith_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	arith_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	// Stall the result side at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Hold the word until it is taken; idle in front of it at random
	task automatic send_word(input in_word_t w);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	function automatic in_word_t make_word(input logic [MODE_W-1:0] m,
			input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
		in_word_t w;
		w.mode      = m;
		w.operand_a = a;
		w.operand_b = b;
		return w;
	endfunction

	// Mix corner values, small and medium magnitudes and full-range values
	function automatic logic [DATA_W-1:0] pick_operand();
		logic [DATA_W-1:0] v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(6))
					0: v = 32'd0;
					1: v = 32'd1;
					2: v = 32'hFFFF_FFFF;
					3: v = 32'h7FFF_FFFF;
					4: v = 32'h8000_0000;
					5: v = 32'd2;
					default: v = 32'hFFFF_FFFE;
				endcase
			end
			1, 2: v = $urandom_range(32) - 16;
			3: begin
				v = $urandom_range(65535);
				if ($urandom_range(1))
					v = 32'd0 - v;
			end
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		int       pick;
		if ($urandom_range(99) < 5)
			w.mode = MODE_W'($urandom_range(MODE_TOP, MODE_SQRT + 1));
		else
			w.mode = MODE_W'($urandom_range(MODE_SQRT, MODE_ADD));
		w.operand_a = pick_operand();
		w.operand_b = pick_operand();
		// keep most exponents small so powers do not collapse to zero or wrap noise
		if (w.mode == MODE_POW) begin
			pick = $urandom_range(99);
			if (pick < 60)
				w.operand_b = $urandom_range(40);
			else if (pick < 75)
				w.operand_b = 32'd0 - $urandom_range(8, 1);
			if ($urandom_range(1))
				w.operand_a = $urandom_range(8) - 4;
		end
		return w;
	endfunction

	task automatic run_phase(input int src_pct, input int sink_pct, input int count);
		gap_pct   = src_pct;
		stall_pct = sink_pct;
		repeat (count)
			send_word(random_word());
	endtask

	// Limit the run
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		gap_pct   = 37;
		stall_pct = 46;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: wrap-around, rounding, error flags and unused codes
		send_word(make_word(MODE_ADD, 32'h7FFF_FFFF, 32'd1));
		send_word(make_word(MODE_SUB, 32'h8000_0000, 32'd1));
		send_word(make_word(MODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_word(make_word(MODE_MUL, 32'h8000_0000, 32'hFFFF_FFFF));
		send_word(make_word(MODE_DIV, 32'd2, 32'd3));
		send_word(make_word(MODE_DIV, 32'd1, 32'd8));
		send_word(make_word(MODE_DIV, 32'hFFFF_FFFF, 32'd8));
		send_word(make_word(MODE_DIV, 32'h8000_0000, 32'hFFFF_FFFF));
		send_word(make_word(MODE_DIV, 32'h8000_0000, 32'd1));
		send_word(make_word(MODE_DIV, 32'd5, 32'd0));
		send_word(make_word(MODE_REM, 32'hFFFF_FFF9, 32'd2));
		send_word(make_word(MODE_REM, 32'h8000_0000, 32'hFFFF_FFFF));
		send_word(make_word(MODE_REM, 32'd5, 32'd0));
		send_word(make_word(MODE_POW, 32'd0, 32'd0));
		send_word(make_word(MODE_POW, 32'd3, 32'd40));
		send_word(make_word(MODE_POW, 32'd1, 32'hFFFF_FFFB));
		send_word(make_word(MODE_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFD));
		send_word(make_word(MODE_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFC));
		send_word(make_word(MODE_POW, 32'd0, 32'hFFFF_FFFF));
		send_word(make_word(MODE_POW, 32'd2, 32'hFFFF_FFFF));
		send_word(make_word(MODE_POW, 32'h8000_0001, 32'h7FFF_FFFF));
		send_word(make_word(MODE_SQUARE, 32'h8000_0000, 32'h7FFF_FFFF));
		send_word(make_word(MODE_CUBE, 32'hFFFF_FAF5, 32'h7FFF_FFFF));
		send_word(make_word(MODE_SQRT, 32'h7FFF_FFFF, 32'd0));
		send_word(make_word(MODE_SQRT, 32'hFFFF_FFFF, 32'd16));
		send_word(make_word(MODE_TOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

		// Random words under three pacing phases
		run_phase(37, 46, WORDS_PER_PHASE);
		run_phase(46, 37, WORDS_PER_PHASE);
		run_phase(0, 0, WORDS_PER_PHASE);
		in_valid <= 1'b0;

		// Drain, then allow for the longest operation
		do @(posedge clk); while (pending_count != 0);
		repeat (100) @(posedge clk);

		$display("Drove %0d operand words over all nine operations and unused codes", words_sent);
		$display("under three handshake pacing phases; %0d result words compared", checked_count);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
